FILE: sv/bestk_pkg.sv
package bestk_pkg;

	// table sizes
	localparam int NUM_KEYS    = 512;
	localparam int NUM_BUTTONS = 8;
	localparam int KEY_AW      = $clog2(NUM_KEYS);
	localparam int BTN_AW      = $clog2(NUM_BUTTONS);

	// action codes
	localparam logic [2:0] ACT_PRESS   = 3'd0;
	localparam logic [2:0] ACT_RELEASE = 3'd1;
	localparam logic [2:0] ACT_TICK    = 3'd2;
	localparam logic [2:0] ACT_QUERY   = 3'd3;
	localparam logic [2:0] ACT_CLEAR   = 3'd4;

	// per-entry button state
	typedef logic [1:0] btn_state_t;
	localparam btn_state_t ST_RELEASED = 2'd0;
	localparam btn_state_t ST_PRESSED  = 2'd1;
	localparam btn_state_t ST_HELD     = 2'd2;

	typedef struct packed {
		logic [2:0] action;
		logic       bank;
		logic [8:0] entry_index;
		logic [7:0] modifier_mask;
	} item_t;

	typedef struct packed {
		logic       is_down;
		logic       just_pressed;
		logic       just_released;
		logic       is_held;
		logic       index_ok;
		logic [7:0] active_modifiers;
	} result_t;

endpackage

FILE: sv/bestk_flags.sv
module bestk_flags
	import bestk_pkg::*;
(
	input  logic       ok,
	input  btn_state_t cur,
	input  btn_state_t prev,
	input  logic [7:0] mods,
	output result_t    res
);

	// flags are forced low for an out-of-range index
	always_comb begin
		res.is_down          = ok && (cur == ST_PRESSED || cur == ST_HELD);
		res.just_pressed     = ok && (cur == ST_PRESSED ||
		                              (cur == ST_HELD && prev == ST_RELEASED));
		res.just_released    = ok && cur == ST_RELEASED && prev != ST_RELEASED;
		res.is_held          = ok && cur == ST_HELD;
		res.index_ok         = ok;
		res.active_modifiers = mods;
	end

endmodule

FILE: sv/button_edge_state_tracker_core.sv
// channel   | ports                 | transfer rule
// ----------+-----------------------+--------------------------------------------
// command   | start, busy, item     | taken at a rising edge with start=1, busy=0
// result    | done, result          | valid for the single cycle done=1
//
// press, release and query: the S_MODIFY state lies between accept and the done cycle, one key table
//   read and one write through the key memory's single read and write port
// frame tick: one key row advanced per cycle by the sweep over the whole key table
// clear all: one key row zeroed per cycle
// after reset the same clearing pass runs with busy high
// results cannot be stalled; every transaction gives exactly one done pulse
module button_edge_state_tracker_core
	import bestk_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_MODIFY,
		S_TICK
	} state_t;

	localparam logic [KEY_AW-1:0] SWEEP_LAST = KEY_AW'(NUM_KEYS - 1);

	// pressed turns into held on a frame tick, everything else stays
	function automatic btn_state_t tick_next(input btn_state_t s);
		btn_state_t r;
		r = (s == ST_PRESSED) ? ST_HELD : s;
		return r;
	endfunction

	state_t            state_q;
	logic [KEY_AW-1:0] sweep_q;
	logic              report_q;   // clear pass owes a result (not the reset pass)
	logic              done_q;
	result_t           result_q;
	logic [7:0]        mods_q;
	btn_state_t        btn_now_q    [NUM_BUTTONS];
	btn_state_t        btn_before_q [NUM_BUTTONS];

	// latched transaction
	item_t             item_q;
	logic              ok_q;
	logic [3:0]        cap_q;       // addressed key row as written by the tick sweep

	// key table: {before, now} per row
	logic [3:0]        key_mem [NUM_KEYS];
	logic [3:0]        rd_data_q;
	logic [KEY_AW-1:0] rd_addr;
	logic              wr_en;
	logic [KEY_AW-1:0] wr_addr;
	logic [3:0]        wr_data;

	logic              accept;
	logic              ok_in;
	logic              is_edit;
	logic              sweep_last;
	logic              key_match;
	logic [KEY_AW-1:0] key_addr;
	logic [BTN_AW-1:0] btn_addr;
	logic [3:0]        btn_word;
	logic [3:0]        cur_word;
	logic [3:0]        adv_word;
	btn_state_t        new_now;
	logic [7:0]        mods_next;
	logic [3:0]        f_word;
	logic [7:0]        f_mods;
	result_t           flags_res;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;
	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		ok_in = item.bank ? (32'(item.entry_index) < NUM_BUTTONS)
		                  : (32'(item.entry_index) < NUM_KEYS);
		key_addr   = KEY_AW'(item_q.entry_index);
		btn_addr   = BTN_AW'(item_q.entry_index);
		is_edit    = (item_q.action == ACT_PRESS) || (item_q.action == ACT_RELEASE);
		sweep_last = (sweep_q == SWEEP_LAST);
		key_match  = (sweep_q == key_addr);

		// read one row ahead during the tick sweep, else the incoming address (row 0 for an incoming tick)
		case (state_q)
			S_TICK:  rd_addr = KEY_AW'(sweep_q + 1'b1);
			default: rd_addr = (item.action == ACT_TICK) ? '0
			                                             : KEY_AW'(item.entry_index);
		endcase

		btn_word = {btn_before_q[btn_addr], btn_now_q[btn_addr]};
		cur_word = item_q.bank ? btn_word : rd_data_q;
		adv_word = {rd_data_q[1:0], tick_next(rd_data_q[1:0])};

		// read-modify-write of the addressed entry
		case (item_q.action)
			ACT_PRESS: begin
				if (item_q.bank || cur_word[1:0] == ST_RELEASED)
					new_now = ST_PRESSED;
				else
					new_now = cur_word[1:0];
			end
			ACT_RELEASE: new_now = ST_RELEASED;
			default:     new_now = cur_word[1:0];
		endcase
		// keyboard edits load the modifier mask even for a bad index
		mods_next = (!item_q.bank && is_edit) ? item_q.modifier_mask : mods_q;

		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = '0;
			end
			S_TICK: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = adv_word;
			end
			S_MODIFY: begin
				wr_en   = ok_q && !item_q.bank && is_edit;
				wr_addr = key_addr;
				wr_data = {rd_data_q[3:2], new_now};
			end
			default: begin
				wr_en   = 1'b0;
				wr_addr = key_addr;
				wr_data = '0;
			end
		endcase

		// what the result reports
		case (state_q)
			S_MODIFY: begin
				f_word = {cur_word[3:2], new_now};
				f_mods = mods_next;
			end
			S_TICK: begin
				if (item_q.bank)
					f_word = btn_word;
				else if (key_match)
					f_word = adv_word;
				else
					f_word = cap_q;
				f_mods = mods_q;
			end
			default: begin
				f_word = '0;
				f_mods = '0;
			end
		endcase
	end

	bestk_flags u_flags (
		.ok   (ok_q),
		.cur  (f_word[1:0]),
		.prev (f_word[3:2]),
		.mods (f_mods),
		.res  (flags_res)
	);

	// key memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			key_mem[wr_addr] <= wr_data;
		rd_data_q <= key_mem[rd_addr];
	end

	// transaction payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			ok_q   <= ok_in;
		end
		if (state_q == S_TICK && key_match)
			cap_q <= adv_word;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			sweep_q  <= '0;
			report_q <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
			mods_q   <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				btn_now_q[i]    <= ST_RELEASED;
				btn_before_q[i] <= ST_RELEASED;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					mods_q <= '0;
					for (int i = 0; i < NUM_BUTTONS; i++) begin
						btn_now_q[i]    <= ST_RELEASED;
						btn_before_q[i] <= ST_RELEASED;
					end
					sweep_q <= KEY_AW'(sweep_q + 1'b1);
					if (sweep_last) begin
						sweep_q  <= '0;
						state_q  <= S_IDLE;
						done_q   <= report_q;
						result_q <= flags_res;
						report_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						sweep_q <= '0;
						case (item.action)
							ACT_TICK: begin
								state_q <= S_TICK;
								// the button table is small enough to advance at once
								for (int i = 0; i < NUM_BUTTONS; i++) begin
									btn_before_q[i] <= btn_now_q[i];
									btn_now_q[i]    <= tick_next(btn_now_q[i]);
								end
							end
							ACT_CLEAR: begin
								state_q  <= S_CLEAR;
								report_q <= 1'b1;
							end
							default: state_q <= S_MODIFY;
						endcase
					end
				end
				S_MODIFY: begin
					if (ok_q && item_q.bank && is_edit)
						btn_now_q[btn_addr] <= new_now;
					mods_q   <= mods_next;
					result_q <= flags_res;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_TICK: begin
					sweep_q <= KEY_AW'(sweep_q + 1'b1);
					if (sweep_last) begin
						sweep_q  <= '0;
						result_q <= flags_res;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/bestk_checker.sv
module bestk_checker
	import bestk_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    done,
	input result_t result
);

	// an accepted transaction makes the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after an accepted transaction");

	// no result can appear in the cycle right after an accept
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result strobe too early after accept");

	// every transaction passes through a busy state before its strobe, so strobes never touch
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe high for two cycles in a row");

	// a bad index reports no key flags
	a_bad_index_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.index_ok |-> !result.is_down && !result.just_pressed &&
		                             !result.just_released && !result.is_held)
		else $error("flags set for an out-of-range index");

	// held implies down, and pressed and released never show together
	a_flags_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!result.is_held || result.is_down) &&
		         !(result.just_pressed && result.just_released))
		else $error("inconsistent result flags");

endmodule

bind button_edge_state_tracker_core bestk_checker u_bestk_checker (.*);

FILE: tb/key_state_checker.sv
`timescale 1ns / 1ps

module key_state_checker
	import bestk_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    done,
	input  result_t result,
	output int      mismatches,
	output int      pending
);

	// shadow copy of the key and mouse button tables
	btn_state_t key_now  [NUM_KEYS];
	btn_state_t key_prev [NUM_KEYS];
	btn_state_t btn_now  [NUM_BUTTONS];
	btn_state_t btn_prev [NUM_BUTTONS];
	logic [7:0] last_mods;

	result_t entry_flags_q[$];
	result_t want;
	int      fail_count;
	int      result_count;

	function automatic void wipe_tables();
		for (int i = 0; i < NUM_KEYS; i++) begin
			key_now[i]  = ST_RELEASED;
			key_prev[i] = ST_RELEASED;
		end
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			btn_now[i]  = ST_RELEASED;
			btn_prev[i] = ST_RELEASED;
		end
		last_mods = '0;
	endfunction

	// update the shadow tables with one event, return the flags of its entry
	function automatic result_t apply_event(item_t ev);
		logic              in_range;
		logic [KEY_AW-1:0] kidx;
		logic [BTN_AW-1:0] bidx;
		btn_state_t        cur;
		btn_state_t        prev;
		result_t           flags;
		in_range = ev.bank ? (ev.entry_index < NUM_BUTTONS) : (ev.entry_index < NUM_KEYS);
		kidx = KEY_AW'(ev.entry_index);
		bidx = BTN_AW'(ev.entry_index);
		cur  = ST_RELEASED;
		prev = ST_RELEASED;
		case (ev.action)
			ACT_PRESS: begin
				if (in_range) begin
					if (ev.bank)
						btn_now[bidx] = ST_PRESSED;
					else if (key_now[kidx] == ST_RELEASED)
						key_now[kidx] = ST_PRESSED;
				end
				if (!ev.bank)
					last_mods = ev.modifier_mask;
			end
			ACT_RELEASE: begin
				if (in_range) begin
					if (ev.bank)
						btn_now[bidx] = ST_RELEASED;
					else
						key_now[kidx] = ST_RELEASED;
				end
				if (!ev.bank)
					last_mods = ev.modifier_mask;
			end
			ACT_TICK: begin
				for (int i = 0; i < NUM_KEYS; i++) begin
					key_prev[i] = key_now[i];
					if (key_now[i] == ST_PRESSED)
						key_now[i] = ST_HELD;
				end
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					btn_prev[i] = btn_now[i];
					if (btn_now[i] == ST_PRESSED)
						btn_now[i] = ST_HELD;
				end
			end
			ACT_CLEAR: wipe_tables();
			default: ;
		endcase
		if (in_range) begin
			cur  = ev.bank ? btn_now[bidx]  : key_now[kidx];
			prev = ev.bank ? btn_prev[bidx] : key_prev[kidx];
		end
		flags.is_down          = in_range && (cur == ST_PRESSED || cur == ST_HELD);
		flags.just_pressed     = in_range && (cur == ST_PRESSED ||
		                                      (cur == ST_HELD && prev == ST_RELEASED));
		flags.just_released    = in_range && cur == ST_RELEASED && prev != ST_RELEASED;
		flags.is_held          = in_range && cur == ST_HELD;
		flags.index_ok         = in_range;
		flags.active_modifiers = last_mods;
		return flags;
	endfunction

	task automatic report_mismatch(string what, int got, int exp_val);
		$display("mismatch on result %0d, %s: got %0h, expected %0h",
		         result_count, what, got, exp_val);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_tables();
			entry_flags_q.delete();
			fail_count   = 0;
			result_count = 0;
			mismatches  <= 0;
			pending     <= 0;
		end else begin
			// results first: a result never belongs to a transaction taken at the same edge
			if (done) begin
				if (entry_flags_q.size() == 0) begin
					report_mismatch("unexpected result", int'(result), 0);
				end else begin
					want = entry_flags_q.pop_front();
					if (result.is_down !== want.is_down)
						report_mismatch("is_down", int'(result.is_down),
						                int'(want.is_down));
					if (result.just_pressed !== want.just_pressed)
						report_mismatch("just_pressed", int'(result.just_pressed),
						                int'(want.just_pressed));
					if (result.just_released !== want.just_released)
						report_mismatch("just_released", int'(result.just_released),
						                int'(want.just_released));
					if (result.is_held !== want.is_held)
						report_mismatch("is_held", int'(result.is_held),
						                int'(want.is_held));
					if (result.index_ok !== want.index_ok)
						report_mismatch("index_ok", int'(result.index_ok),
						                int'(want.index_ok));
					if (result.active_modifiers !== want.active_modifiers)
						report_mismatch("active_modifiers", int'(result.active_modifiers),
						                int'(want.active_modifiers));
				end
				result_count++;
			end
			if (start && !busy)
				entry_flags_q = {entry_flags_q, apply_event(item)};
			mismatches <= fail_count;
			pending    <= entry_flags_q.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import bestk_pkg::*;

	// action codes the block has no use for; it treats them as a query
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_MID   = 3'd6;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

	localparam int EVENTS_PER_PHASE = 333;
	// quiet cycles allowed: a tick sweeps the whole key table, plus the longest gap
	localparam int QUIET_LIMIT      = 8 * NUM_KEYS + 100;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;
	int      mismatches;
	int      pending;
	int      quiet_cycles;
	int      idle_pct;

	button_edge_state_tracker_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	key_state_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// present one event from the falling edge and hold it until it is taken;
	// start stays high so back-to-back transactions need no re-arm
	task automatic send_event(logic [2:0] action, logic bank, logic [8:0] index,
	                          logic [7:0] mods);
		@(negedge clk);
		start <= 1'b1;
		item  <= '{action: action, bank: bank, entry_index: index, modifier_mask: mods};
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_cycles(int count);
		@(negedge clk);
		start <= 1'b0;
		repeat (count - 1) @(negedge clk);
	endtask

	task automatic drain_results();
		do @(posedge clk); while (pending != 0);
	endtask

	// random event: most traffic hits a few keys and the real buttons so that
	// press, tick and release sequences actually chain on the same entries
	task automatic send_random_event();
		int         pick;
		logic [2:0] action;
		logic       bank;
		logic [8:0] index;
		pick = $urandom_range(99);
		if (pick < 35)
			action = ACT_PRESS;
		else if (pick < 60)
			action = ACT_RELEASE;
		else if (pick < 67)
			action = ACT_TICK;
		else if (pick < 90)
			action = ACT_QUERY;
		else if (pick < 92)
			action = ACT_CLEAR;
		else
			action = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
		bank = ($urandom_range(3) == 0);
		if ($urandom_range(99) < 85)
			index = bank ? 9'($urandom_range(NUM_BUTTONS - 1)) : 9'($urandom_range(15));
		else
			index = 9'($urandom_range(511));
		send_event(action, bank, index, 8'($urandom_range(255)));
	endtask

	// watchdog: a run with no transaction in either direction for too long is hung
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: key extremes, held and released edges
		send_event(ACT_PRESS,   1'b0, 9'd511, 8'hFF);
		send_event(ACT_PRESS,   1'b0, 9'd0,   8'h00);
		send_event(ACT_QUERY,   1'b0, 9'd511, 8'h00);
		send_event(ACT_TICK,    1'b0, 9'd511, 8'hFF);
		// press on a held key keeps it held
		send_event(ACT_PRESS,   1'b0, 9'd511, 8'h3C);
		send_event(ACT_RELEASE, 1'b0, 9'd511, 8'h5A);
		send_event(ACT_QUERY,   1'b0, 9'd0,   8'hFF);
		send_event(ACT_TICK,    1'b1, 9'd0,   8'h00);
		send_event(ACT_QUERY,   1'b0, 9'd511, 8'h00);
		// mouse: top button, out of range indexes, re-press of a held button
		send_event(ACT_PRESS,   1'b1, 9'd7,   8'hA5);
		send_event(ACT_PRESS,   1'b1, 9'd8,   8'hFF);
		send_event(ACT_RELEASE, 1'b1, 9'd511, 8'h00);
		send_event(ACT_TICK,    1'b0, 9'd7,   8'h00);
		send_event(ACT_QUERY,   1'b1, 9'd7,   8'h00);
		send_event(ACT_PRESS,   1'b1, 9'd7,   8'h00);
		send_event(ACT_RELEASE, 1'b1, 9'd7,   8'hFF);
		send_event(ACT_QUERY,   1'b1, 9'd0,   8'h00);
		// spare action codes behave as a query
		send_event(ACT_SPARE_FIRST, 1'b0, 9'd0,   8'hFF);
		send_event(ACT_SPARE_MID,   1'b1, 9'd7,   8'hFF);
		send_event(ACT_SPARE_LAST,  1'b0, 9'd511, 8'hFF);
		// clear from a busy table, then look at what it left
		send_event(ACT_PRESS,   1'b0, 9'd256, 8'h81);
		send_event(ACT_CLEAR,   1'b1, 9'd7,   8'hFF);
		send_event(ACT_QUERY,   1'b0, 9'd256, 8'h00);
		send_event(ACT_QUERY,   1'b1, 9'd7,   8'h00);

		// random phases: sender gaps none, heavy, light
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 1) ? 60 : (phase == 2) ? 12 : 0;
			for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
				if ($urandom_range(99) < idle_pct)
					idle_cycles($urandom_range(6, 1));
				send_random_event();
			end
			// hold off until every outstanding result is back
			idle_cycles(1);
			drain_results();
		end

		// tail: a frame tick or a clear is the longest operation
		repeat (NUM_KEYS + 16) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

FILE: button_edge_state_tracker_core.f
sv/bestk_pkg.sv
sv/bestk_flags.sv
sv/button_edge_state_tracker_core.sv
sv/bestk_checker.sv
tb/key_state_checker.sv
tb/testbench.sv
